// ===== rtl/mtq_pkg.sv =====
package mtq_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int DATA_W          = 32;

    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic push;
        logic rd;
        logic pop;
    } stk_cmd_t;

    typedef struct packed {
        logic     start;
        stk_cmd_t in_cmd;
        stk_cmd_t out_cmd;
        logic     set_full;
        logic     set_empty;
        logic     take_deq;
        logic     load_res;
    } dp_cmd_t;

    typedef struct packed {
        logic in_empty;
        logic in_full;
        logic in_last;
        logic out_empty;
        logic res_busy;
    } dp_stat_t;

endpackage

// ===== rtl/min_tracking_queue_unit.sv =====
// Queue of signed 32-bit words built from an inbound and an outbound stack, each
// tracking its running minimum; every request returns one result with status,
// the dequeued word, the current minimum and the held count. An enqueue steps
// through S_ENQ and S_RESULT, a dequeue with a non-empty outbound stack through
// S_POP_RD, S_POP_WR and S_RESULT, and a dequeue that refills first repeats
// S_XFER_RD then S_XFER_WR for each inbound word moved across. Each stack memory
// has a single read port with registered read data, so every move is a read
// state then a write state. A finished result waits in the output register, and
// a stalled output holds the block in its result state. Each stack holds
// STACK_DEPTH words; enqueue reports full when the inbound stack is full.
module min_tracking_queue_unit #(
    parameter int STACK_DEPTH = mtq_pkg::STACK_DEPTH_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      req_valid,
    output logic                                      req_stall,
    input  logic                                      req_type,
    input  logic signed [mtq_pkg::DATA_W-1:0]         enq_value,
    output logic                                      res_valid,
    input  logic                                      res_stall,
    output logic        [1:0]                         status,
    output logic signed [mtq_pkg::DATA_W-1:0]         deq_value,
    output logic signed [mtq_pkg::DATA_W-1:0]         min_value,
    output logic                                      min_valid,
    output logic        [$clog2(2*STACK_DEPTH+1)-1:0] held_count
);
    import mtq_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    mtq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_type  (req_type),
        .stat      (stat),
        .cmd       (cmd)
    );

    mtq_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .enq_value  (enq_value),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .status     (status),
        .deq_value  (deq_value),
        .min_value  (min_value),
        .min_valid  (min_valid),
        .held_count (held_count)
    );

endmodule

// ===== rtl/mtq_stack.sv =====
module mtq_stack #(
    parameter int DEPTH = mtq_pkg::STACK_DEPTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  mtq_pkg::stk_cmd_t                      cmd,
    input  logic signed [mtq_pkg::DATA_W-1:0]      push_data,
    output logic        [$clog2(DEPTH+1)-1:0]      depth,
    output logic signed [mtq_pkg::DATA_W-1:0]      top_min,
    output logic signed [mtq_pkg::DATA_W-1:0]      rd_data
);
    import mtq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    // running minimum of entries 0..i kept next to each word
    logic signed [DATA_W-1:0] data_mem [DEPTH];
    logic signed [DATA_W-1:0] runmin_mem [DEPTH];

    logic        [CW-1:0]     depth_reg;
    logic        [CW-1:0]     depth_next;
    logic signed [DATA_W-1:0] top_reg;
    logic signed [DATA_W-1:0] rd_data_reg;
    logic signed [DATA_W-1:0] rd_min_reg;
    logic signed [DATA_W-1:0] new_min;
    logic        [CW-1:0]     top_idx;
    logic        [CW-1:0]     below_idx;
    logic        [AW-1:0]     wr_addr;
    logic        [AW-1:0]     rd_addr;
    logic        [AW-1:0]     min_addr;

    assign top_idx   = depth_reg - CW'(1);
    assign below_idx = (depth_reg >= CW'(2)) ? depth_reg - CW'(2) : '0;
    assign wr_addr   = depth_reg[AW-1:0];
    assign rd_addr   = top_idx[AW-1:0];
    assign min_addr  = below_idx[AW-1:0];
    assign new_min   = (depth_reg == '0 || push_data < top_reg) ? push_data : top_reg;

    always_comb
    begin
        depth_next = depth_reg;
        if (cmd.push)
        begin
            depth_next = depth_reg + CW'(1);
        end
        else if (cmd.pop)
        begin
            depth_next = depth_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
        end
        else
        begin
            depth_reg <= depth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            data_mem[wr_addr]   <= push_data;
            runmin_mem[wr_addr] <= new_min;
            top_reg             <= new_min;
        end
        else if (cmd.pop)
        begin
            top_reg <= rd_min_reg;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= data_mem[rd_addr];
            rd_min_reg  <= runmin_mem[min_addr];
        end
    end

    assign depth   = depth_reg;
    assign top_min = top_reg;
    assign rd_data = rd_data_reg;

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= FULL_CNT)
        else $error("stack depth beyond capacity");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> depth_reg != FULL_CNT)
        else $error("push on full stack");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pop || cmd.rd) |-> depth_reg != '0)
        else $error("read or pop on empty stack");

    a_pop_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> $past(cmd.rd))
        else $error("pop without preceding read");

endmodule

// ===== rtl/mtq_datapath.sv =====
module mtq_datapath #(
    parameter int STACK_DEPTH = mtq_pkg::STACK_DEPTH_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  mtq_pkg::dp_cmd_t                              cmd,
    output mtq_pkg::dp_stat_t                             stat,
    input  logic signed [mtq_pkg::DATA_W-1:0]             enq_value,
    output logic                                          res_valid,
    input  logic                                          res_stall,
    output logic        [1:0]                             status,
    output logic signed [mtq_pkg::DATA_W-1:0]             deq_value,
    output logic signed [mtq_pkg::DATA_W-1:0]             min_value,
    output logic                                          min_valid,
    output logic        [$clog2(2*STACK_DEPTH+1)-1:0]     held_count
);
    import mtq_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int HW = $clog2(2 * STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);

    logic        [CW-1:0]     in_depth;
    logic        [CW-1:0]     out_depth;
    logic signed [DATA_W-1:0] in_top;
    logic signed [DATA_W-1:0] out_top;
    logic signed [DATA_W-1:0] in_rd;
    logic signed [DATA_W-1:0] out_rd;

    logic signed [DATA_W-1:0] value_reg;
    status_t                  status_reg;
    status_t                  status_next;
    logic signed [DATA_W-1:0] deq_reg;

    logic                     res_valid_reg;
    logic                     res_valid_next;
    status_t                  res_status_reg;
    logic signed [DATA_W-1:0] res_deq_reg;
    logic signed [DATA_W-1:0] res_min_reg;
    logic                     res_min_ok_reg;
    logic        [HW-1:0]     res_count_reg;

    logic                     in_ok;
    logic                     out_ok;
    logic signed [DATA_W-1:0] cur_min;

    mtq_stack #(.DEPTH(STACK_DEPTH)) u_in_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd.in_cmd),
        .push_data (value_reg),
        .depth     (in_depth),
        .top_min   (in_top),
        .rd_data   (in_rd)
    );

    mtq_stack #(.DEPTH(STACK_DEPTH)) u_out_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd.out_cmd),
        .push_data (in_rd),
        .depth     (out_depth),
        .top_min   (out_top),
        .rd_data   (out_rd)
    );

    assign in_ok  = (in_depth != '0);
    assign out_ok = (out_depth != '0);

    always_comb
    begin
        if (in_ok && out_ok)
        begin
            cur_min = (out_top < in_top) ? out_top : in_top;
        end
        else if (in_ok)
        begin
            cur_min = in_top;
        end
        else if (out_ok)
        begin
            cur_min = out_top;
        end
        else
        begin
            cur_min = '0;
        end
    end

    always_comb
    begin
        status_next = status_reg;
        if (cmd.set_empty)
        begin
            status_next = ST_EMPTY;
        end
        else if (cmd.set_full)
        begin
            status_next = ST_FULL;
        end
        else if (cmd.start)
        begin
            status_next = ST_OK;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg && res_stall;
        if (cmd.load_res)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        if (cmd.start)
        begin
            value_reg <= enq_value;
        end
        if (cmd.take_deq)
        begin
            deq_reg <= out_rd;
        end
        else if (cmd.start)
        begin
            deq_reg <= '0;
        end
        if (cmd.load_res)
        begin
            res_status_reg <= status_reg;
            res_deq_reg    <= deq_reg;
            res_min_reg    <= cur_min;
            res_min_ok_reg <= in_ok || out_ok;
            res_count_reg  <= HW'(in_depth) + HW'(out_depth);
        end
    end

    assign stat.in_empty  = !in_ok;
    assign stat.in_full   = (in_depth == FULL_CNT);
    assign stat.in_last   = (in_depth == CW'(1));
    assign stat.out_empty = !out_ok;
    assign stat.res_busy  = res_valid_reg && res_stall;

    assign res_valid  = res_valid_reg;
    assign status     = res_status_reg;
    assign deq_value  = res_deq_reg;
    assign min_value  = res_min_reg;
    assign min_valid  = res_min_ok_reg;
    assign held_count = res_count_reg;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_res |-> !(res_valid_reg && res_stall))
        else $error("result overwritten while stalled");

    a_xfer_pair: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_cmd.push |-> cmd.in_cmd.pop)
        else $error("refill push without inbound pop");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (HW'(in_depth) + HW'(out_depth)) <= HW'(2 * STACK_DEPTH))
        else $error("held count beyond capacity");

endmodule

// ===== rtl/mtq_ctrl.sv =====
module mtq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  logic              req_type,
    input  mtq_pkg::dp_stat_t stat,
    output mtq_pkg::dp_cmd_t  cmd
);
    import mtq_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_ENQ     = 7'b0000010,
        S_XFER_RD = 7'b0000100,
        S_XFER_WR = 7'b0001000,
        S_POP_RD  = 7'b0010000,
        S_POP_WR  = 7'b0100000,
        S_RESULT  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.start = 1'b1;
                    if (req_type == REQ_ENQ)
                    begin
                        state_next = S_ENQ;
                    end
                    else if (!stat.out_empty)
                    begin
                        state_next = S_POP_RD;
                    end
                    else if (!stat.in_empty)
                    begin
                        state_next = S_XFER_RD;
                    end
                    else
                    begin
                        cmd.set_empty = 1'b1;
                        state_next    = S_RESULT;
                    end
                end
            end
            S_ENQ:
            begin
                if (stat.in_full)
                begin
                    cmd.set_full = 1'b1;
                end
                else
                begin
                    cmd.in_cmd.push = 1'b1;
                end
                state_next = S_RESULT;
            end
            S_XFER_RD:
            begin
                cmd.in_cmd.rd = 1'b1;
                state_next    = S_XFER_WR;
            end
            S_XFER_WR:
            begin
                cmd.in_cmd.pop   = 1'b1;
                cmd.out_cmd.push = 1'b1;
                state_next       = stat.in_last ? S_POP_RD : S_XFER_RD;
            end
            S_POP_RD:
            begin
                cmd.out_cmd.rd = 1'b1;
                state_next     = S_POP_WR;
            end
            S_POP_WR:
            begin
                cmd.out_cmd.pop = 1'b1;
                cmd.take_deq    = 1'b1;
                state_next      = S_RESULT;
            end
            S_RESULT:
            begin
                if (!stat.res_busy)
                begin
                    cmd.load_res = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_result_next: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ENQ || state_reg == S_POP_WR) |=> state_reg == S_RESULT)
        else $error("operation did not reach result");

    a_refill_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_XFER_RD && $past(state_reg) == S_IDLE) |->
            (stat.out_empty && !stat.in_empty))
        else $error("refill with outbound not empty");

endmodule
